FILE: hw/rtl/ubf_pkg.sv
// ubf_pkg: shared types, codes and helpers for the buffered uart back end
// no dependencies; imported by every module under hw/rtl
package ubf_pkg;

  // default sizes
  localparam int RX_DEPTH_DEF = 256;
  localparam int TX_DEPTH_DEF = 256;
  localparam int SEQ_MAX_DEF  = 8;

  // operation codes
  localparam logic [2:0] OP_RX_BYTE   = 3'd0;
  localparam logic [2:0] OP_LINE_ERR  = 3'd1;
  localparam logic [2:0] OP_HOST_RD   = 3'd2;
  localparam logic [2:0] OP_HOST_WR   = 3'd3;
  localparam logic [2:0] OP_TX_READY  = 3'd4;
  localparam logic [2:0] OP_CLR_ERRS  = 3'd5;

  // register indexes on the config port
  localparam logic [1:0] REG_MATCH_SEQ = 2'd0;
  localparam logic [1:0] REG_MATCH_LEN = 2'd1;
  localparam logic [1:0] REG_TX_ENABLE = 2'd2;

  localparam int          LEVEL_W   = 9;
  localparam int          TALLY_W   = 16;
  localparam logic [7:0]  MARK_BYTE = 8'h7F;
  localparam logic [TALLY_W-1:0] TALLY_MAX = 16'hFFFF;

  // result fields except the popped byte, which comes from a fifo read register
  typedef struct packed {
    logic               data_valid;
    logic               data_from_tx;
    logic               sequence_hit;
    logic               write_accepted;
    logic               tx_idle;
    logic [LEVEL_W-1:0] rx_level;
    logic [LEVEL_W-1:0] tx_space;
    logic [TALLY_W-1:0] buffer_overrun_count;
    logic [TALLY_W-1:0] line_overrun_count;
    logic [TALLY_W-1:0] framing_count;
  } ubf_res_t;

  // saturating tally increment
  function automatic logic [TALLY_W-1:0] tally_bump(input logic [TALLY_W-1:0] v);
    logic [TALLY_W-1:0] r;
    r = (v == TALLY_MAX) ? TALLY_MAX : v + 1'b1;
    return r;
  endfunction

endpackage

FILE: hw/rtl/ubf_fifo.sv
// ubf_fifo: byte fifo with circular store, head/tail pointers and fill count
// a paired push writes the marker byte now and the data byte next cycle
// depends on ubf_pkg
module ubf_fifo import ubf_pkg::*; #(
  parameter int DEPTH = RX_DEPTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic          pair,
  input  logic [7:0]    wdata,
  input  logic          pop,
  output logic [CW-1:0] fill,
  output logic [7:0]    rdata,
  output logic          busy
);

  logic [7:0]    store_r [DEPTH];
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          pend_r, pend_nxt;
  logic [7:0]    pend_data_r;
  logic [7:0]    rdata_r;
  logic          wr_en;
  logic [7:0]    wr_data;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    r = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  assign wr_en   = push | pend_r;
  assign wr_data = pend_r ? pend_data_r : (pair ? MARK_BYTE : wdata);

  always_comb begin
    tail_nxt = wr_en ? ptr_inc(tail_r) : tail_r;
    head_nxt = pop ? ptr_inc(head_r) : head_r;
    fill_nxt = fill_r + CW'(wr_en) - CW'(pop);
    pend_nxt = push & pair;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
      pend_r <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fill_r <= fill_nxt;
      pend_r <= pend_nxt;
    end
  end

  // store and read register, no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[tail_r] <= wr_data;
    end
    if (pop) begin
      rdata_r <= store_r[head_r];
    end
    if (push & pair) begin
      pend_data_r <= wdata;
    end
  end

  assign fill  = fill_r;
  assign rdata = rdata_r;
  assign busy  = pend_r;

endmodule

FILE: hw/rtl/ubf_match.sv
// ubf_match: naive sequence matcher over received bytes
// depends on ubf_pkg
module ubf_match import ubf_pkg::*; #(
  parameter int SEQ_MAX = SEQ_MAX_DEF,
  localparam int PW = (SEQ_MAX > 1) ? $clog2(SEQ_MAX) : 1
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic [7:0]  rx_byte,
  input  logic [63:0] seq,
  input  logic [3:0]  len,
  output logic        hit
);

  logic [PW-1:0] progress_r, progress_nxt;
  logic [7:0]    seq_bytes [SEQ_MAX];
  logic [3:0]    eff_len;
  logic [7:0]    want;
  logic          last;

  always_comb begin
    for (int k = 0; k < SEQ_MAX; k++) begin
      seq_bytes[k] = seq[8*k +: 8];
    end
  end

  // zero acts as one, anything above the maximum acts as the maximum
  always_comb begin
    if (len == 4'd0) begin
      eff_len = 4'd1;
    end else if (len > 4'(SEQ_MAX)) begin
      eff_len = 4'(SEQ_MAX);
    end else begin
      eff_len = len;
    end
  end

  assign want = seq_bytes[progress_r];
  assign last = (4'(progress_r) + 4'd1) >= eff_len;

  always_comb begin
    progress_nxt = progress_r;
    hit          = 1'b0;
    if (en) begin
      if (rx_byte != want) begin
        progress_nxt = '0;
      end else if (last) begin
        progress_nxt = '0;
        hit          = 1'b1;
      end else begin
        progress_nxt = progress_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      progress_r <= '0;
    end else begin
      progress_r <= progress_nxt;
    end
  end

endmodule

FILE: hw/rtl/uart_buffered_fifo_with_sequence_detect.sv
// uart_buffered_fifo_with_sequence_detect: top level of the buffered uart back end
// holds the config registers, error tallies, event decode and result stages
// depends on ubf_pkg, ubf_fifo and ubf_match
//
//   channel   ports                           direction  handshake
//   input     in_operation .. in_line_framing in         in_valid / in_ready
//   result    out_out_data .. out_framing_count out      out_valid / out_ready
//   config    psel penable pwrite paddr ...   in/out     apb, pready tied high
//
// one item per cycle; each event is at most one push or pop plus tally and matcher updates
// an rx byte arriving with an overrun pending and room for two holds in_ready low while
// the rx store takes its second write (single write port)
// results go to a staging register and then the output register, so two results may
// wait while out_ready is low; once both are full in_ready drops
// rst_n is synchronous; fifos empty, tallies and matcher cleared, match_length back to one
module uart_buffered_fifo_with_sequence_detect import ubf_pkg::*; #(
  parameter int RX_DEPTH = RX_DEPTH_DEF,
  parameter int TX_DEPTH = TX_DEPTH_DEF,
  parameter int SEQ_MAX  = SEQ_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input items
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_operation,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_line_overrun,
  input  logic                 in_line_framing,
  // result items
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_out_data,
  output logic                 out_data_valid,
  output logic                 out_sequence_hit,
  output logic                 out_write_accepted,
  output logic                 out_tx_idle,
  output logic [LEVEL_W-1:0]   out_rx_level,
  output logic [LEVEL_W-1:0]   out_tx_space,
  output logic [TALLY_W-1:0]   out_buffer_overrun_count,
  output logic [TALLY_W-1:0]   out_line_overrun_count,
  output logic [TALLY_W-1:0]   out_framing_count,
  // config port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready
);

  localparam int RX_CW = $clog2(RX_DEPTH + 1);
  localparam int TX_CW = $clog2(TX_DEPTH + 1);

  // config registers
  logic [63:0] match_seq_r;
  logic [3:0]  match_len_r;
  logic        tx_en_r;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  // fifo control
  logic             rx_push, rx_pair, rx_pop, rx_busy;
  logic [7:0]       rx_wdata, rx_rdata;
  logic [RX_CW-1:0] rx_fill, rx_fill_after;
  logic             tx_push, tx_pop, tx_busy;
  logic [7:0]       tx_rdata;
  logic [TX_CW-1:0] tx_fill, tx_fill_after;
  logic             rx_room1, rx_room2, tx_room;

  // matcher
  logic match_en, match_hit;

  // state
  logic               pend_r, pend_nxt;
  logic [TALLY_W-1:0] buf_tally_r, buf_tally_nxt;
  logic [TALLY_W-1:0] line_tally_r, line_tally_nxt;
  logic [TALLY_W-1:0] fr_tally_r, fr_tally_nxt;

  // result stages
  logic     in_acc;
  ubf_res_t res;
  ubf_res_t stg_r;
  logic     stg_v_r, stg_v_nxt;
  logic     stg_move;
  ubf_res_t out_r;
  logic [7:0] out_data_r;
  logic     out_v_r, out_v_nxt;

  // ---------------------------------------------------------------- config port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:3];
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_seq_r <= '0;
      match_len_r <= 4'd1;
      tx_en_r     <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MATCH_SEQ: match_seq_r <= pwdata;
        REG_MATCH_LEN: match_len_r <= pwdata[3:0];
        REG_TX_ENABLE: tx_en_r     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MATCH_SEQ: prdata = match_seq_r;
      REG_MATCH_LEN: prdata = {60'd0, match_len_r};
      REG_TX_ENABLE: prdata = {63'd0, tx_en_r};
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- handshake
  // staging register frees when it can move on to the output register
  assign stg_move = stg_v_r & (~out_v_r | out_ready);
  assign in_ready = ~rx_busy & ~tx_busy & (~stg_v_r | stg_move);
  assign in_acc   = in_valid & in_ready;

  // ---------------------------------------------------------------- event decode
  assign rx_room1 = rx_fill < RX_CW'(RX_DEPTH);
  assign rx_room2 = rx_fill < RX_CW'(RX_DEPTH - 1);
  assign tx_room  = tx_fill < TX_CW'(TX_DEPTH);

  always_comb begin
    rx_push        = 1'b0;
    rx_pair        = 1'b0;
    rx_wdata       = in_data_byte;
    rx_pop         = 1'b0;
    tx_push        = 1'b0;
    tx_pop         = 1'b0;
    match_en       = 1'b0;
    pend_nxt       = pend_r;
    buf_tally_nxt  = buf_tally_r;
    line_tally_nxt = line_tally_r;
    fr_tally_nxt   = fr_tally_r;
    res            = '0;
    if (in_acc) begin
      unique case (in_operation)
        OP_RX_BYTE: begin
          match_en = 1'b1;
          if (pend_r) begin
            // marker first; the byte follows only if a second slot is free
            if (rx_room1) begin
              pend_nxt = 1'b0;
              rx_push  = 1'b1;
              rx_pair  = rx_room2;
              if (!rx_room2) begin
                rx_wdata = MARK_BYTE;
              end
            end
          end else if (rx_room1) begin
            rx_push = 1'b1;
          end else begin
            buf_tally_nxt = tally_bump(buf_tally_r);
            pend_nxt      = 1'b1;
          end
        end
        OP_LINE_ERR: begin
          if (in_line_overrun) begin
            line_tally_nxt = tally_bump(line_tally_r);
          end
          if (in_line_framing) begin
            fr_tally_nxt = tally_bump(fr_tally_r);
          end
          if ((in_line_overrun | in_line_framing) && rx_room1) begin
            rx_push  = 1'b1;
            rx_wdata = MARK_BYTE;
          end
        end
        OP_HOST_RD: begin
          if (rx_fill != '0) begin
            rx_pop         = 1'b1;
            res.data_valid = 1'b1;
          end
        end
        OP_HOST_WR: begin
          if (tx_room) begin
            tx_push            = 1'b1;
            res.write_accepted = 1'b1;
          end
        end
        OP_TX_READY: begin
          if (tx_en_r) begin
            if (tx_fill != '0) begin
              tx_pop           = 1'b1;
              res.data_valid   = 1'b1;
              res.data_from_tx = 1'b1;
            end else begin
              res.tx_idle = 1'b1;
            end
          end
        end
        OP_CLR_ERRS: begin
          buf_tally_nxt  = '0;
          line_tally_nxt = '0;
          fr_tally_nxt   = '0;
        end
        default: ;
      endcase
    end
    res.sequence_hit = match_hit;
    // read-clear reports the tallies as they stood before clearing
    if (in_operation == OP_CLR_ERRS) begin
      res.buffer_overrun_count = buf_tally_r;
      res.line_overrun_count   = line_tally_r;
      res.framing_count        = fr_tally_r;
    end else begin
      res.buffer_overrun_count = buf_tally_nxt;
      res.line_overrun_count   = line_tally_nxt;
      res.framing_count        = fr_tally_nxt;
    end
    res.rx_level = LEVEL_W'(rx_fill_after);
    res.tx_space = LEVEL_W'(TX_CW'(TX_DEPTH) - tx_fill_after);
  end

  // levels after this item, counting both writes of a paired push
  assign rx_fill_after = rx_fill + RX_CW'(rx_push) + RX_CW'(rx_pair) - RX_CW'(rx_pop);
  assign tx_fill_after = tx_fill + TX_CW'(tx_push) - TX_CW'(tx_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r       <= 1'b0;
      buf_tally_r  <= '0;
      line_tally_r <= '0;
      fr_tally_r   <= '0;
    end else begin
      pend_r       <= pend_nxt;
      buf_tally_r  <= buf_tally_nxt;
      line_tally_r <= line_tally_nxt;
      fr_tally_r   <= fr_tally_nxt;
    end
  end

  // ---------------------------------------------------------------- sub-blocks
  ubf_fifo #(.DEPTH(RX_DEPTH)) u_rx_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rx_push),
    .pair  (rx_pair),
    .wdata (rx_wdata),
    .pop   (rx_pop),
    .fill  (rx_fill),
    .rdata (rx_rdata),
    .busy  (rx_busy)
  );

  // transmit side never needs a paired push
  ubf_fifo #(.DEPTH(TX_DEPTH)) u_tx_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (tx_push),
    .pair  (1'b0),
    .wdata (in_data_byte),
    .pop   (tx_pop),
    .fill  (tx_fill),
    .rdata (tx_rdata),
    .busy  (tx_busy)
  );

  ubf_match #(.SEQ_MAX(SEQ_MAX)) u_match (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (match_en),
    .rx_byte (in_data_byte),
    .seq     (match_seq_r),
    .len     (match_len_r),
    .hit     (match_hit)
  );

  // ---------------------------------------------------------------- result stages
  // popped byte sits in the fifo read register until the next pop of that fifo,
  // which can only happen as the staged item moves on
  always_comb begin
    stg_v_nxt = stg_v_r;
    if (in_acc) begin
      stg_v_nxt = 1'b1;
    end else if (stg_move) begin
      stg_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (stg_move) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      stg_v_r <= stg_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      stg_r <= res;
    end
    if (stg_move) begin
      out_r <= stg_r;
      if (!stg_r.data_valid) begin
        out_data_r <= 8'd0;
      end else if (stg_r.data_from_tx) begin
        out_data_r <= tx_rdata;
      end else begin
        out_data_r <= rx_rdata;
      end
    end
  end

  assign out_valid                = out_v_r;
  assign out_out_data             = out_data_r;
  assign out_data_valid           = out_r.data_valid;
  assign out_sequence_hit         = out_r.sequence_hit;
  assign out_write_accepted       = out_r.write_accepted;
  assign out_tx_idle              = out_r.tx_idle;
  assign out_rx_level             = out_r.rx_level;
  assign out_tx_space             = out_r.tx_space;
  assign out_buffer_overrun_count = out_r.buffer_overrun_count;
  assign out_line_overrun_count   = out_r.line_overrun_count;
  assign out_framing_count        = out_r.framing_count;

endmodule
